// File: sv/uras_pkg.sv
`timescale 1ns / 1ps

package uras_pkg;

	localparam int NUM_LEDS       = 4;
	localparam int MAX_DATA_BYTES = 3;
	localparam int DATA_BYTES     = 3;
	localparam int LED_IW         = $clog2((NUM_LEDS > 1) ? NUM_LEDS : 2);
	localparam int Q_DEPTH        = 2;
	localparam int Q_PW           = $clog2(Q_DEPTH);
	localparam int Q_CW           = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] FUNC_RX      = 2'd0;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
	localparam logic [1:0] FUNC_BUTTON  = 2'd2;

	localparam logic [7:0] READ_FLAG = 8'h80;
	localparam logic [6:0] REG_MASK  = 7'h7F;
	localparam logic [6:0] REG_BUTTON = 7'd0;

	localparam logic [2:0] BEAT_ADDR  = 3'd0;
	localparam logic [2:0] BEAT_REG   = 3'd1;
	localparam logic [2:0] BEAT_CNT_H = 3'd2;
	localparam logic [2:0] BEAT_CNT_L = 3'd3;
	localparam logic [2:0] BEAT_DATA  = 3'd4;

	typedef enum logic {
		PH_HEADER,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		HDR_REG,
		HDR_LEN_HI,
		HDR_LEN_LO
	} hdr_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic [7:0] button_value;
	} item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_last;
		logic       led_update;
		logic [2:0] led_number;
		logic [7:0] led_red;
		logic [7:0] led_green;
		logic [7:0] led_blue;
	} result_t;

	typedef struct packed {
		logic [7:0]  slave_addr;
		logic [7:0]  reg_byte;
		logic [1:0]  count;
		logic        is_read;
		logic [23:0] rd_data;
		logic        led_update;
		logic [2:0]  led_number;
		logic [23:0] led_rgb;
	} reply_t;

	function automatic logic [1:0] clip_len(input logic [15:0] len, input logic [1:0] lim);
		clip_len = (len < {14'd0, lim}) ? len[1:0] : lim;
	endfunction

endpackage

// File: sv/uart_register_access_slave.sv
`timescale 1ns / 1ps
// channel   handshake          payload
// item      push / full        item   (func, rx_byte, button_value)
// result    empty / pop        result (tx_byte, tx_last, led_*)
// config    cfg_we             cfg_data (device address)
//
// One input beat is taken per cycle while the reply queue has room.
// A reply frame of 4 to 7 beats leaves one beat per cycle from the output
// register while pop stays high. empty falls once the accepted beat's reply has
// passed through the reply queue and been loaded into the output register.
// arst_n clears the frame state, button and LED registers; address resets to 1.
// A stalled result holds; full rises when two replies are waiting.

module uart_register_access_slave (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  uras_pkg::item_t    item,
	output logic               empty,
	input  logic               pop,
	output uras_pkg::result_t  result,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data
);

	logic [7:0]        addr_q;
	logic              q_push, q_pop, q_valid;
	uras_pkg::reply_t  q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 8'd1;
		end else begin
			if (cfg_we) begin
				addr_q <= cfg_data;
			end
		end
	end

	uras_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (push && !full),
		.item       (item),
		.slave_addr (addr_q),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	uras_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	uras_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// File: sv/uras_front.sv
`timescale 1ns / 1ps

module uras_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  uras_pkg::item_t    item,
	input  logic [7:0]         slave_addr,
	output logic               q_push,
	output uras_pkg::reply_t   q_data
);

	localparam logic [1:0] MAXB = 2'(uras_pkg::MAX_DATA_BYTES);

	uras_pkg::phase_t phase_q, phase_n;
	uras_pkg::hdr_t   hdr_q, hdr_n;
	logic [7:0]  reg_q, reg_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  db_q [uras_pkg::DATA_BYTES];
	logic [7:0]  db_n [uras_pkg::DATA_BYTES];
	logic [1:0]  dc_q, dc_n;
	logic [7:0]  btn_q, btn_n;
	logic [23:0] led_q [uras_pkg::NUM_LEDS];
	logic        led_we;
	logic [uras_pkg::LED_IW-1:0] led_idx;
	logic        fin, reply;
	logic [6:0]  reg7;
	logic [1:0]  lim, want;
	logic        is_led;
	logic [23:0] rd_rgb;

	always_comb begin
		phase_n = phase_q;
		hdr_n   = hdr_q;
		reg_n   = reg_q;
		len_n   = len_q;
		db_n    = db_q;
		dc_n    = dc_q;
		btn_n   = btn_q;
		fin     = 1'b0;
		reply   = 1'b0;
		want    = uras_pkg::clip_len(len_q, MAXB);
		case (item.func)
			uras_pkg::FUNC_BUTTON: begin
				btn_n = item.button_value;
			end
			uras_pkg::FUNC_TIMEOUT: begin
				if (phase_q == uras_pkg::PH_DATA) begin
					fin = 1'b1;
				end else begin
					hdr_n = uras_pkg::HDR_REG;
				end
			end
			uras_pkg::FUNC_RX: begin
				if (phase_q == uras_pkg::PH_DATA) begin
					if (dc_q < 2'(uras_pkg::DATA_BYTES)) begin
						db_n[dc_q] = item.rx_byte;
					end
					dc_n = dc_q + 2'd1;
					if (dc_n >= want) begin
						fin = 1'b1;
					end
				end else begin
					case (hdr_q)
						uras_pkg::HDR_REG: begin
							reg_n = item.rx_byte;
							hdr_n = uras_pkg::HDR_LEN_HI;
						end
						uras_pkg::HDR_LEN_HI: begin
							len_n = {item.rx_byte, 8'd0};
							hdr_n = uras_pkg::HDR_LEN_LO;
						end
						default: begin
							len_n = {len_q[15:8], item.rx_byte};
							hdr_n = uras_pkg::HDR_REG;
							if ((reg_q & uras_pkg::READ_FLAG) != 8'd0 || len_n == 16'd0) begin
								reply = 1'b1;
							end else begin
								phase_n = uras_pkg::PH_DATA;
								dc_n    = 2'd0;
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		reg7    = reg_n[6:0] & uras_pkg::REG_MASK;
		is_led  = (reg7 != uras_pkg::REG_BUTTON) && (reg7 <= 7'(uras_pkg::NUM_LEDS));
		led_idx = uras_pkg::LED_IW'(reg7 - 7'd1);
		led_we  = 1'b0;
		if (fin) begin
			phase_n = uras_pkg::PH_HEADER;
			dc_n    = 2'd0;
			reply   = 1'b1;
			if (reg7 == uras_pkg::REG_BUTTON) begin
				btn_n = db_n[0];
			end else if (is_led) begin
				led_we = 1'b1;
			end
		end

		lim    = (reg7 == uras_pkg::REG_BUTTON) ? 2'd1 : MAXB;
		rd_rgb = is_led ? led_q[led_idx] : 24'd0;

		q_push              = accept && reply;
		q_data.slave_addr   = slave_addr;
		q_data.reg_byte     = reg_n;
		q_data.count        = (reg7 > 7'(uras_pkg::NUM_LEDS)) ? 2'd0 : uras_pkg::clip_len(len_n, lim);
		q_data.is_read      = reg_n[7];
		q_data.rd_data      = (reg7 == uras_pkg::REG_BUTTON) ? {3{btn_q}} : rd_rgb;
		q_data.led_update   = led_we;
		q_data.led_number   = led_we ? reg7[2:0] : 3'd0;
		q_data.led_rgb      = led_we ? {db_n[0], db_n[1], db_n[2]} : 24'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= uras_pkg::PH_HEADER;
			hdr_q   <= uras_pkg::HDR_REG;
			reg_q   <= 8'd0;
			len_q   <= 16'd0;
			dc_q    <= 2'd0;
			btn_q   <= 8'd0;
			for (int i = 0; i < uras_pkg::DATA_BYTES; i++) begin
				db_q[i] <= 8'd0;
			end
			for (int i = 0; i < uras_pkg::NUM_LEDS; i++) begin
				led_q[i] <= 24'd0;
			end
		end else if (accept) begin
			phase_q <= phase_n;
			hdr_q   <= hdr_n;
			reg_q   <= reg_n;
			len_q   <= len_n;
			dc_q    <= dc_n;
			btn_q   <= btn_n;
			db_q    <= db_n;
			if (led_we) begin
				led_q[led_idx] <= {db_n[0], db_n[1], db_n[2]};
			end
		end
	end

endmodule

// File: sv/uras_queue.sv
`timescale 1ns / 1ps

module uras_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  uras_pkg::reply_t   wdata,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output uras_pkg::reply_t   rdata
);

	uras_pkg::reply_t mem_q [uras_pkg::Q_DEPTH];
	logic [uras_pkg::Q_PW-1:0] wp_q, rp_q;
	logic [uras_pkg::Q_CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == uras_pkg::Q_CW'(uras_pkg::Q_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rdata   = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == uras_pkg::Q_PW'(uras_pkg::Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == uras_pkg::Q_PW'(uras_pkg::Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/uras_back.sv
`timescale 1ns / 1ps

module uras_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  uras_pkg::reply_t   q_data,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output uras_pkg::result_t  result
);

	logic              out_valid_q;
	uras_pkg::result_t out_q;
	logic [2:0]        k_q;
	logic [2:0]        len;
	logic              last, load;
	logic [1:0]        di;
	uras_pkg::result_t beat;

	assign len   = uras_pkg::BEAT_DATA + (q_data.is_read ? {1'b0, q_data.count} : 3'd0);
	assign last  = (k_q == len - 3'd1);
	assign load  = q_valid && (!out_valid_q || pop);
	assign q_pop = load && last;
	assign di    = 2'(k_q - uras_pkg::BEAT_DATA);
	assign empty = !out_valid_q;
	assign result = out_q;

	always_comb begin
		beat            = '0;
		beat.tx_last    = last;
		case (k_q)
			uras_pkg::BEAT_ADDR: begin
				beat.tx_byte    = q_data.slave_addr;
				beat.led_update = q_data.led_update;
				beat.led_number = q_data.led_number;
				beat.led_red    = q_data.led_rgb[23:16];
				beat.led_green  = q_data.led_rgb[15:8];
				beat.led_blue   = q_data.led_rgb[7:0];
			end
			uras_pkg::BEAT_REG:   beat.tx_byte = q_data.reg_byte;
			uras_pkg::BEAT_CNT_H: beat.tx_byte = 8'd0;
			uras_pkg::BEAT_CNT_L: beat.tx_byte = {6'd0, q_data.count};
			default: begin
				case (di)
					2'd0:    beat.tx_byte = q_data.rd_data[23:16];
					2'd1:    beat.tx_byte = q_data.rd_data[15:8];
					default: beat.tx_byte = q_data.rd_data[7:0];
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q         <= uras_pkg::BEAT_ADDR;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q         <= last ? uras_pkg::BEAT_ADDR : k_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/uras_checker.sv
`timescale 1ns / 1ps

module uras_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  logic               pop,
	input  uras_pkg::result_t  result
);

	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.tx_last) |=> !empty)
		else $error("reply frame broken mid-way");

	a_led_number: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.led_update) |-> (result.led_number != 3'd0))
		else $error("led update without led number");

	a_led_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.led_update) |->
		(result.led_number == 3'd0 && result.led_red == 8'd0 &&
		 result.led_green == 8'd0 && result.led_blue == 8'd0))
		else $error("led fields set without update");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("stalled result changed");

endmodule

bind uart_register_access_slave uras_checker u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
